[src/ppcf_pkg.sv]
// ============================================================================
// Plane penalty contact force package
// Shared widths, operation and register codes, the contact bitmap write
// request, and the Q16.16 rounding and saturation helpers.
// ============================================================================
`default_nettype none

package ppcf_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int IDX_W          = 10;
    localparam int Q_W            = 32;
    localparam int OP_W           = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int GAIN_W         = 31;
    localparam int RANGE_W        = 11;
    localparam int PROD_W         = 64;
    localparam int RND_W          = PROD_W - 16;

    localparam logic [OP_W-1:0] OP_FORCE   = 2'd0;
    localparam logic [OP_W-1:0] OP_DIFF    = 2'd1;
    localparam logic [OP_W-1:0] OP_REFRESH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LAST   = 3'd7;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             value;
    } t_bit_wr;

    // Rounds a Q32.32 product to Q32.16, half up.
    function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] q;
        q = v + 64'sd32768;
        return q[PROD_W-1:16];
    endfunction

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/ppcf_contact_mem.sv]
// ============================================================================
// Plane penalty contact bitmap
// One contact bit per point with one write and one registered read per cycle.
// A write in the same cycle as a read of the same point is forwarded. After
// reset a sweep clears every entry, one per cycle, while busy is high.
// ============================================================================
`default_nettype none

module ppcf_contact_mem #(
    parameter int MAX_POINTS = ppcf_pkg::MAX_POINTS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire ppcf_pkg::t_bit_wr     i_wr,
    input  wire                        i_rd_en,
    input  wire [ppcf_pkg::IDX_W-1:0]  i_rd_idx,
    output logic                       o_rd_bit,
    output logic                       o_busy
);
    import ppcf_pkg::*;

    localparam int          AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [31:0] DEPTH = 32'(MAX_POINTS);
    localparam logic [AW-1:0] LAST = AW'(MAX_POINTS - 1);

    logic          r_mem [0:MAX_POINTS-1];
    logic          r_busy;
    logic [AW-1:0] r_clr_cnt;
    logic          r_rd_bit;

    logic          wr_ok;
    logic          rd_ok;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign wr_ok   = i_wr.en && (32'(i_wr.idx) < DEPTH);
    assign rd_ok   = 32'(i_rd_idx) < DEPTH;
    assign wr_addr = AW'(i_wr.idx);
    assign rd_addr = AW'(i_rd_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_cnt] <= 1'b0;
        end else if (wr_ok) begin
            r_mem[wr_addr] <= i_wr.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (!rd_ok) begin
                r_rd_bit <= 1'b0;
            end else if (wr_ok && (i_wr.idx == i_rd_idx)) begin
                r_rd_bit <= i_wr.value;
            end else begin
                r_rd_bit <= r_mem[rd_addr];
            end
        end
    end

    assign o_rd_bit = r_rd_bit;
    assign o_busy   = r_busy;

endmodule

`default_nettype wire

[src/plane_penalty_contact_force.sv]
// ============================================================================
// Plane penalty contact force
// Streams points against a configured plane and returns the updated force or
// differential accumulator, the contact decision and the penetration depth.
// ============================================================================
// The block takes one transaction per clock while the output is not stalled
// and returns one result per transaction, in order. The eight-stage pipeline
// does the 32 by 32 bit multiplies in stages 1, 3 and 5 and the rounding,
// sums and saturation in stages 2, 4, 6 and 7; the contact bitmap takes one
// read and one write per cycle, and a write from a force or refresh
// transaction is forwarded to a differential transaction right behind it.
// After reset the bitmap is cleared entry by entry, during which o_in_ready
// stays low; configuration writes are taken at any time but must only be
// issued while no transaction is in flight.
`default_nettype none

module plane_penalty_contact_force #(
    parameter int MAX_POINTS = ppcf_pkg::MAX_POINTS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,

    input  wire                               i_cfg_we,
    input  wire [ppcf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [ppcf_pkg::Q_W-1:0]           i_cfg_data,

    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire [ppcf_pkg::OP_W-1:0]          i_operation,
    input  wire [ppcf_pkg::IDX_W-1:0]         i_point_index,
    input  wire signed [ppcf_pkg::Q_W-1:0]    i_a_x,
    input  wire signed [ppcf_pkg::Q_W-1:0]    i_a_y,
    input  wire signed [ppcf_pkg::Q_W-1:0]    i_a_z,
    input  wire signed [ppcf_pkg::Q_W-1:0]    i_b_x,
    input  wire signed [ppcf_pkg::Q_W-1:0]    i_b_y,
    input  wire signed [ppcf_pkg::Q_W-1:0]    i_b_z,
    input  wire signed [ppcf_pkg::Q_W-1:0]    i_acc_x,
    input  wire signed [ppcf_pkg::Q_W-1:0]    i_acc_y,
    input  wire signed [ppcf_pkg::Q_W-1:0]    i_acc_z,
    input  wire signed [ppcf_pkg::Q_W-1:0]    i_k_factor,

    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic signed [ppcf_pkg::Q_W-1:0]   o_sum_x,
    output logic signed [ppcf_pkg::Q_W-1:0]   o_sum_y,
    output logic signed [ppcf_pkg::Q_W-1:0]   o_sum_z,
    output logic                              o_in_contact,
    output logic signed [ppcf_pkg::Q_W-1:0]   o_depth
);
    import ppcf_pkg::*;

    localparam int NSTG = 8;

    // Configuration registers.
    logic signed [Q_W-1:0]  r_normal [3];
    logic signed [Q_W-1:0]  r_offset;
    logic [GAIN_W-1:0]      r_stiff;
    logic [GAIN_W-1:0]      r_damp;
    logic [RANGE_W-1:0]     r_range_first;
    logic [RANGE_W-1:0]     r_range_last;

    // Pipeline control.
    logic [NSTG-1:0]        r_v;
    logic [NSTG-1:0]        en;
    logic                   busy;
    logic                   accept;

    // Stage 0: captured transaction.
    logic [OP_W-1:0]        r0_op;
    logic [IDX_W-1:0]       r0_idx;
    logic signed [Q_W-1:0]  r0_a [3];
    logic signed [Q_W-1:0]  r0_b [3];
    logic signed [Q_W-1:0]  r0_acc [3];
    logic signed [Q_W-1:0]  r0_kf;

    // Stage 1: raw products.
    logic [OP_W-1:0]          r1_op;
    logic [IDX_W-1:0]         r1_idx;
    logic signed [PROD_W-1:0] r1_pa [3];
    logic signed [PROD_W-1:0] r1_pk;
    logic signed [Q_W-1:0]    r1_b [3];
    logic signed [Q_W-1:0]    r1_acc [3];

    // Stage 2: depth, projection and differential factor.
    logic [OP_W-1:0]        r2_op;
    logic [IDX_W-1:0]       r2_idx;
    logic signed [Q_W-1:0]  r2_dep;
    logic signed [Q_W-1:0]  r2_proj;
    logic signed [Q_W-1:0]  r2_fact;
    logic                   r2_hit;
    logic signed [Q_W-1:0]  r2_b [3];
    logic signed [Q_W-1:0]  r2_acc [3];

    // Stage 3: gain products.
    logic                     r3_diff;
    logic                     r3_contact;
    logic                     r3_apply;
    logic signed [Q_W-1:0]    r3_dep;
    logic signed [PROD_W-1:0] r3_p1;
    logic signed [PROD_W-1:0] r3_p2;
    logic signed [Q_W-1:0]    r3_b [3];
    logic signed [Q_W-1:0]    r3_acc [3];

    // Stage 4: rounded gains.
    logic                   r4_contact;
    logic                   r4_apply;
    logic signed [Q_W-1:0]  r4_dep;
    logic signed [Q_W-1:0]  r4_g1;
    logic signed [Q_W-1:0]  r4_g2;
    logic signed [Q_W-1:0]  r4_b [3];
    logic signed [Q_W-1:0]  r4_acc [3];

    // Stage 5: per-axis products.
    logic                     r5_contact;
    logic                     r5_apply;
    logic signed [Q_W-1:0]    r5_dep;
    logic signed [PROD_W-1:0] r5_m [3];
    logic signed [PROD_W-1:0] r5_q [3];
    logic signed [Q_W-1:0]    r5_acc [3];

    // Stage 6: per-axis terms.
    logic                   r6_contact;
    logic                   r6_apply;
    logic signed [Q_W-1:0]  r6_dep;
    logic signed [Q_W-1:0]  r6_t [3];
    logic signed [Q_W-1:0]  r6_acc [3];

    // Stage 7: output register.
    logic                   r7_contact;
    logic signed [Q_W-1:0]  r7_dep;
    logic signed [Q_W-1:0]  r7_sum [3];

    // Combinational stage logic.
    logic signed [RND_W-1:0]  c2_rnd [3];
    logic signed [PROD_W-1:0] c2_dot;
    logic signed [Q_W-1:0]    c2_dep;
    logic                     c2_in_range;
    logic                     rd_bit;
    logic                     c3_force_like;
    logic                     c3_contact;
    logic signed [Q_W-1:0]    stiff_s;
    logic signed [Q_W-1:0]    damp_s;
    logic signed [PROD_W-1:0] c3_p1;
    logic signed [PROD_W-1:0] c3_p2;
    t_bit_wr                  bit_wr;

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal[0]   <= 32'sd0;
            r_normal[1]   <= 32'sd65536;
            r_normal[2]   <= 32'sd0;
            r_offset      <= 32'sd0;
            r_stiff       <= 31'd65536;
            r_damp        <= 31'd0;
            r_range_first <= '1;
            r_range_last  <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NORMAL_X:     r_normal[0]   <= i_cfg_data;
                CFG_NORMAL_Y:     r_normal[1]   <= i_cfg_data;
                CFG_NORMAL_Z:     r_normal[2]   <= i_cfg_data;
                CFG_PLANE_OFFSET: r_offset      <= i_cfg_data;
                CFG_STIFFNESS:    r_stiff       <= i_cfg_data[GAIN_W-1:0];
                CFG_DAMPING:      r_damp        <= i_cfg_data[GAIN_W-1:0];
                CFG_RANGE_FIRST:  r_range_first <= i_cfg_data[RANGE_W-1:0];
                CFG_RANGE_LAST:   r_range_last  <= i_cfg_data[RANGE_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its item moves on.
    // ------------------------------------------------------------------------
    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_in_ready = en[0] && !busy;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= accept;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_op     <= i_operation;
            r0_idx    <= i_point_index;
            r0_a[0]   <= i_a_x;
            r0_a[1]   <= i_a_y;
            r0_a[2]   <= i_a_z;
            r0_b[0]   <= i_b_x;
            r0_b[1]   <= i_b_y;
            r0_b[2]   <= i_b_z;
            r0_acc[0] <= i_acc_x;
            r0_acc[1] <= i_acc_y;
            r0_acc[2] <= i_acc_z;
            r0_kf     <= i_k_factor;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1
    // ------------------------------------------------------------------------
    assign stiff_s = $signed({1'b0, r_stiff});
    assign damp_s  = $signed({1'b0, r_damp});

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_op  <= r0_op;
            r1_idx <= r0_idx;
            r1_pk  <= -(stiff_s * r0_kf);
            for (int i = 0; i < 3; i++) begin
                r1_pa[i]  <= r0_a[i] * r_normal[i];
                r1_b[i]   <= r0_b[i];
                r1_acc[i] <= r0_acc[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2
    // ------------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c2_rnd[i] = rnd16(r1_pa[i]);
        end
        c2_dot = 64'(c2_rnd[0]) + 64'(c2_rnd[1]) + 64'(c2_rnd[2]);
        c2_dep = sat32(c2_dot - 64'(r_offset));
        c2_in_range = !(!r_range_first[RANGE_W-1] &&
                        (r1_idx < r_range_first[IDX_W-1:0])) &&
                      !(!r_range_last[RANGE_W-1] &&
                        (r1_idx > r_range_last[IDX_W-1:0]));
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_op   <= r1_op;
            r2_idx  <= r1_idx;
            r2_dep  <= c2_dep;
            r2_proj <= sat32(c2_dot);
            r2_fact <= sat32(64'(rnd16(r1_pk)));
            r2_hit  <= c2_in_range && c2_dep[Q_W-1];
            for (int i = 0; i < 3; i++) begin
                r2_b[i]   <= r1_b[i];
                r2_acc[i] <= r1_acc[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Contact bitmap: read as an item enters stage 2, written as a force or refresh item leaves it.
    // ------------------------------------------------------------------------
    assign c3_force_like = (r2_op == OP_FORCE) || (r2_op == OP_REFRESH);

    always_comb begin
        bit_wr.en    = en[3] && r_v[2] && c3_force_like;
        bit_wr.idx   = r2_idx;
        bit_wr.value = r2_hit;
    end

    ppcf_contact_mem #(
        .MAX_POINTS (MAX_POINTS)
    ) u_contact_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (bit_wr),
        .i_rd_en  (en[2]),
        .i_rd_idx (r1_idx),
        .o_rd_bit (rd_bit),
        .o_busy   (busy)
    );

    // ------------------------------------------------------------------------
    // Stage 3
    // ------------------------------------------------------------------------
    always_comb begin
        if (r2_op == OP_DIFF) begin
            c3_contact = rd_bit;
            c3_p1      = r2_fact * r2_proj;
            c3_p2      = '0;
        end else begin
            c3_contact = c3_force_like && r2_hit;
            c3_p1      = -(stiff_s * r2_dep);
            c3_p2      = -(damp_s * r2_dep);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_diff    <= r2_op == OP_DIFF;
            r3_contact <= c3_contact;
            r3_apply   <= c3_contact && ((r2_op == OP_FORCE) || (r2_op == OP_DIFF));
            r3_dep     <= c3_force_like ? r2_dep : '0;
            r3_p1      <= c3_p1;
            r3_p2      <= c3_p2;
            for (int i = 0; i < 3; i++) begin
                r3_b[i]   <= r2_b[i];
                r3_acc[i] <= r2_acc[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_contact <= r3_contact;
            r4_apply   <= r3_apply;
            r4_dep     <= r3_dep;
            r4_g1      <= sat32(64'(rnd16(r3_p1)));
            r4_g2      <= r3_diff ? '0 : sat32(64'(rnd16(r3_p2)));
            for (int i = 0; i < 3; i++) begin
                r4_b[i]   <= r3_b[i];
                r4_acc[i] <= r3_acc[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_contact <= r4_contact;
            r5_apply   <= r4_apply;
            r5_dep     <= r4_dep;
            for (int i = 0; i < 3; i++) begin
                r5_m[i]   <= r_normal[i] * r4_g1;
                r5_q[i]   <= r4_b[i] * r4_g2;
                r5_acc[i] <= r4_acc[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_contact <= r5_contact;
            r6_apply   <= r5_apply;
            r6_dep     <= r5_dep;
            for (int i = 0; i < 3; i++) begin
                r6_t[i]   <= sat32(64'(rnd16(r5_m[i])) - 64'(rnd16(r5_q[i])));
                r6_acc[i] <= r5_acc[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 7
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_contact <= r6_contact;
            r7_dep     <= r6_dep;
            for (int i = 0; i < 3; i++) begin
                r7_sum[i] <= r6_apply ? sat32(64'(r6_acc[i]) + 64'(r6_t[i])) : r6_acc[i];
            end
        end
    end

    assign o_out_valid  = r_v[NSTG-1];
    assign o_sum_x      = r7_sum[0];
    assign o_sum_y      = r7_sum[1];
    assign o_sum_z      = r7_sum[2];
    assign o_in_contact = r7_contact;
    assign o_depth      = r7_dep;

endmodule

`default_nettype wire

[tb/tb_plane_penalty_contact_force.sv]
// ============================================================================
// Plane penalty contact force testbench
// Sends point transactions through the block under random stalls on both
// sides, predicts every result from a local model of the plane, the gains,
// the index range and the contact bitmap, and checks each result in order.
// ============================================================================
module tb_plane_penalty_contact_force;
    import ppcf_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam logic signed [Q_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic [Q_W-1:0] NO_BOUND = 32'hFFFF_FFFF;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic [IDX_W-1:0]        idx;
        logic signed [Q_W-1:0]   ax, ay, az;
        logic signed [Q_W-1:0]   bx, by, bz;
        logic signed [Q_W-1:0]   acc_x, acc_y, acc_z;
        logic signed [Q_W-1:0]   kf;
    } t_point;

    typedef struct {
        logic signed [Q_W-1:0]   sum_x, sum_y, sum_z;
        logic                    contact;
        logic signed [Q_W-1:0]   depth;
    } t_contact_result;

    typedef struct {
        logic [Q_W-1:0] nx, ny, nz, plane_off;
        logic [Q_W-1:0] stiff, damp;
        logic [Q_W-1:0] idx_first, idx_last;
    } t_plane_setup;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [Q_W-1:0]          i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [OP_W-1:0]         i_operation = '0;
    logic [IDX_W-1:0]        i_point_index = '0;
    logic signed [Q_W-1:0]   i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [Q_W-1:0]   i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic signed [Q_W-1:0]   i_acc_x = '0, i_acc_y = '0, i_acc_z = '0;
    logic signed [Q_W-1:0]   i_k_factor = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [Q_W-1:0]   o_sum_x, o_sum_y, o_sum_z;
    logic                    o_in_contact;
    logic signed [Q_W-1:0]   o_depth;

    longint pl_nx = 0, pl_ny = 65536, pl_nz = 0, pl_off = 0;
    longint pl_stiff = 65536, pl_damp = 0, pl_first = -1, pl_last = -1;
    bit     contact_map [0:MAX_POINTS_DEF-1];

    t_contact_result expected_sums[$];
    t_contact_result oldest;
    int mismatches = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_len = 0;

    plane_penalty_contact_force uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_operation(i_operation), .i_point_index(i_point_index),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_z(i_b_z),
        .i_acc_x(i_acc_x), .i_acc_y(i_acc_y), .i_acc_z(i_acc_z),
        .i_k_factor(i_k_factor),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_sum_x(o_sum_x), .o_sum_y(o_sum_y), .o_sum_z(o_sum_z),
        .o_in_contact(o_in_contact), .o_depth(o_depth)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint q_round(longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        return q_round(a * b);
    endfunction

    function automatic t_contact_result contact_response(t_point p);
        t_contact_result r;
        longint nrm[3], a[3], b[3], acc[3], sum[3];
        longint dep, fi, di, fact, proj, scale;
        bit in_range, hit;
        nrm[0] = pl_nx;
        nrm[1] = pl_ny;
        nrm[2] = pl_nz;
        a[0] = longint'(p.ax);
        a[1] = longint'(p.ay);
        a[2] = longint'(p.az);
        b[0] = longint'(p.bx);
        b[1] = longint'(p.by);
        b[2] = longint'(p.bz);
        acc[0] = longint'(p.acc_x);
        acc[1] = longint'(p.acc_y);
        acc[2] = longint'(p.acc_z);
        sum = acc;
        dep = 0;
        hit = 1'b0;
        if (p.op == OP_FORCE || p.op == OP_REFRESH) begin
            in_range = 1'b1;
            if (pl_first >= 0 && longint'(p.idx) < pl_first) in_range = 1'b0;
            if (pl_last >= 0 && longint'(p.idx) > pl_last) in_range = 1'b0;
            dep = clamp32(q_mul(a[0], nrm[0]) + q_mul(a[1], nrm[1]) +
                          q_mul(a[2], nrm[2]) - pl_off);
            hit = in_range && dep < 0;
            contact_map[p.idx] = hit;
            if (p.op == OP_FORCE && hit) begin
                fi = clamp32(q_round(-(pl_stiff * dep)));
                di = clamp32(q_round(-(pl_damp * dep)));
                for (int i = 0; i < 3; i++) begin
                    sum[i] = clamp32(acc[i] + clamp32(q_mul(nrm[i], fi) - q_mul(b[i], di)));
                end
            end
        end else if (p.op == OP_DIFF) begin
            hit = contact_map[p.idx];
            if (hit) begin
                fact = clamp32(q_round(-(pl_stiff * longint'(p.kf))));
                proj = clamp32(q_mul(a[0], nrm[0]) + q_mul(a[1], nrm[1]) +
                               q_mul(a[2], nrm[2]));
                scale = clamp32(q_mul(fact, proj));
                for (int i = 0; i < 3; i++) begin
                    sum[i] = clamp32(acc[i] + clamp32(q_mul(nrm[i], scale)));
                end
            end
        end
        r.sum_x = sum[0][31:0];
        r.sum_y = sum[1][31:0];
        r.sum_z = sum[2][31:0];
        r.contact = hit;
        r.depth = dep[31:0];
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] near_q();
        return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
    endfunction

    function automatic logic signed [Q_W-1:0] rand_q();
        int r;
        r = $urandom_range(15);
        if (r < 9) begin
            return $signed($urandom_range(0, 32'h100000)) - 32'sh80000;
        end else if (r < 13) begin
            return $urandom;
        end else if (r == 13) begin
            return Q_MAX;
        end else if (r == 14) begin
            return Q_MIN;
        end
        return $signed($urandom_range(0, 2)) - 1;
    endfunction

    function automatic t_point mk_point(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                        logic signed [Q_W-1:0] ax, ay, az, bx, by, bz,
                                        logic signed [Q_W-1:0] cx, cy, cz, kf);
        t_point p;
        p.op = op;
        p.idx = idx;
        p.ax = ax;
        p.ay = ay;
        p.az = az;
        p.bx = bx;
        p.by = by;
        p.bz = bz;
        p.acc_x = cx;
        p.acc_y = cy;
        p.acc_z = cz;
        p.kf = kf;
        return p;
    endfunction

    function automatic t_point pass_point(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
        t_point p;
        p = mk_point(op, idx, near_q(), near_q(), near_q(), rand_q(), rand_q(), rand_q(),
                     rand_q(), rand_q(), rand_q(), rand_q());
        if ($urandom_range(9) == 0) begin
            p.ax = rand_q();
            p.ay = rand_q();
            p.az = rand_q();
        end
        return p;
    endfunction

    function automatic logic [Q_W-1:0] random_gain();
        case ($urandom_range(5))
            0: return 32'h0001_0000;
            1: return $urandom_range(0, 32'h0100_0000);
            2: return $urandom;
            3: return 32'h7FFF_FFFF;
            default: return 32'h0;
        endcase
    endfunction

    function automatic t_plane_setup random_plane();
        t_plane_setup s;
        int axis, lo, hi;
        s.nx = 0;
        s.ny = 0;
        s.nz = 0;
        case ($urandom_range(4))
            0: begin
                axis = $urandom_range(2);
                if (axis == 0) s.nx = $urandom_range(1) ? Q_ONE : -Q_ONE;
                if (axis == 1) s.ny = $urandom_range(1) ? Q_ONE : -Q_ONE;
                if (axis == 2) s.nz = $urandom_range(1) ? Q_ONE : -Q_ONE;
            end
            1: begin
                s.nx = $urandom_range(1) ? 32'sd46341 : -32'sd46341;
                s.ny = $urandom_range(1) ? 32'sd46341 : -32'sd46341;
                s.nz = $urandom_range(1) ? 32'sd46341 : -32'sd46341;
                case ($urandom_range(2))
                    0: s.nx = 0;
                    1: s.ny = 0;
                    default: s.nz = 0;
                endcase
            end
            2: begin
                s.nx = $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
                s.ny = $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
                s.nz = $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
            end
            3: begin
                s.nx = rand_q();
                s.ny = rand_q();
                s.nz = rand_q();
            end
            default: begin
                s.nx = $urandom_range(1) ? Q_MAX : Q_MIN;
                s.ny = $urandom_range(1) ? Q_MAX : Q_MIN;
                s.nz = $urandom_range(1) ? Q_MAX : Q_MIN;
            end
        endcase
        if ($urandom_range(3) == 0) begin
            s.plane_off = rand_q();
        end else begin
            s.plane_off = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
        end
        s.stiff = random_gain();
        s.damp = $urandom_range(2) == 0 ? 32'h0 : random_gain();
        case ($urandom_range(5))
            0, 1: begin
                s.idx_first = NO_BOUND;
                s.idx_last = NO_BOUND;
            end
            2: begin
                lo = $urandom_range(1) ? 0 : $urandom_range(0, 1023);
                hi = $urandom_range(1) ? 1023 : $urandom_range(lo, 1023);
                s.idx_first = lo;
                s.idx_last = hi;
            end
            3: begin
                s.idx_first = -$urandom_range(2, 1024);
                s.idx_last = $urandom_range(1) ? NO_BOUND : -$urandom_range(2, 1024);
            end
            4: begin
                lo = $urandom_range(1, 1023);
                s.idx_first = lo;
                s.idx_last = $urandom_range(0, lo - 1);
            end
            default: begin
                s.idx_first = $urandom;
                s.idx_last = $urandom;
            end
        endcase
        return s;
    endfunction

    task automatic send_point(t_point p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= p.op;
        i_point_index <= p.idx;
        i_a_x <= p.ax;
        i_a_y <= p.ay;
        i_a_z <= p.az;
        i_b_x <= p.bx;
        i_b_y <= p.by;
        i_b_z <= p.bz;
        i_acc_x <= p.acc_x;
        i_acc_y <= p.acc_y;
        i_acc_z <= p.acc_z;
        i_k_factor <= p.kf;
        expected_sums = {expected_sums, contact_response(p)};
        items_sent++;
        do begin
            @(posedge i_clk);
        end while (o_in_ready !== 1'b1);
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_setup(t_plane_setup s);
        write_reg(CFG_NORMAL_X, s.nx);
        write_reg(CFG_NORMAL_Y, s.ny);
        write_reg(CFG_NORMAL_Z, s.nz);
        write_reg(CFG_PLANE_OFFSET, s.plane_off);
        write_reg(CFG_STIFFNESS, s.stiff);
        write_reg(CFG_DAMPING, s.damp);
        write_reg(CFG_RANGE_FIRST, s.idx_first);
        write_reg(CFG_RANGE_LAST, s.idx_last);
        i_cfg_we <= 1'b0;
        pl_nx = longint'($signed(s.nx));
        pl_ny = longint'($signed(s.ny));
        pl_nz = longint'($signed(s.nz));
        pl_off = longint'($signed(s.plane_off));
        pl_stiff = longint'(s.stiff[GAIN_W-1:0]);
        pl_damp = longint'(s.damp[GAIN_W-1:0]);
        pl_first = longint'($signed(s.idx_first[RANGE_W-1:0]));
        pl_last = longint'($signed(s.idx_last[RANGE_W-1:0]));
    endtask

    task automatic stray_point();
        if ($urandom_range(99) < 12) begin
            send_point(mk_point(OP_W'($urandom_range(3)), IDX_W'($urandom_range(1023)),
                                rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                                rand_q(), rand_q(), rand_q(), rand_q()));
        end
    endtask

    // A force or refresh sweep over a run of points, then differential sweeps
    // over the same points, with stray transactions mixed in.
    task automatic contact_pass();
        int k, base, sweeps;
        logic [OP_W-1:0] op;
        k = $urandom_range(4, 24);
        base = $urandom_range(7) == 0 ? 1024 - k : $urandom_range(0, 1024 - k);
        op = $urandom_range(3) == 0 ? OP_REFRESH : OP_FORCE;
        sweeps = $urandom_range(1, 3);
        for (int j = 0; j < k; j++) begin
            stray_point();
            send_point(pass_point(op, 10'(base + j)));
        end
        for (int s = 0; s < sweeps; s++) begin
            for (int j = 0; j < k; j++) begin
                stray_point();
                send_point(pass_point(OP_DIFF, 10'(base + j)));
            end
        end
        if ($urandom_range(19) == 0) wait_results_done();
    endtask

    task automatic test_directed_cases();
        t_plane_setup s;
        send_idle_pct = 0;
        recv_idle_pct = 20;
        send_point(mk_point(OP_REFRESH, 0, 0, -Q_ONE, 0, 0, 0, 0, 0, 0, 0, 0));
        send_point(mk_point(OP_DIFF, 0, 0, Q_ONE / 2, 0, 0, 0, 0,
                            Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_ONE));
        send_point(mk_point(OP_FORCE, 1, 3 * Q_ONE, -2 * Q_ONE, 5 * Q_ONE,
                            Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0));
        send_point(mk_point(OP_FORCE, 2, 0, Q_ONE, 0, Q_ONE, 0, 0, Q_ONE, 0, 0, 0));
        send_point(mk_point(OP_DIFF, 2, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0,
                            Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        send_point(mk_point(OP_NONE, 0, -Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                            5, 6, 7, Q_ONE));
        send_point(mk_point(OP_DIFF, 0, Q_ONE, -Q_ONE, Q_ONE, 0, 0, 0, 0, 0, 0, 2 * Q_ONE));
        send_point(mk_point(OP_FORCE, 3, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE, 1, 1, 1, 0));
        send_point(mk_point(OP_FORCE, 1023, 0, Q_MIN, 0, Q_MAX, Q_MIN, Q_MAX,
                            Q_MAX, Q_MAX, Q_MAX, 0));
        send_point(mk_point(OP_DIFF, 1023, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0,
                            Q_MIN, Q_MIN, Q_MIN, Q_MAX));
        send_point(mk_point(OP_FORCE, 4, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN,
                            Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_point(mk_point(OP_REFRESH, 0, 0, Q_ONE, 0, 0, 0, 0, 0, 0, 0, 0));
        send_point(mk_point(OP_DIFF, 0, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 1, 2, 3, Q_ONE));
        wait_results_done();

        s.nx = 0;
        s.ny = 0;
        s.nz = Q_ONE;
        s.plane_off = Q_ONE;
        s.stiff = 100 * Q_ONE;
        s.damp = Q_ONE / 2;
        s.idx_first = 5;
        s.idx_last = 10;
        load_setup(s);
        send_point(mk_point(OP_FORCE, 4, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0));
        send_point(mk_point(OP_FORCE, 5, 0, 0, -Q_ONE, 2 * Q_ONE, -3 * Q_ONE, 4 * Q_ONE,
                            Q_ONE, Q_ONE, Q_ONE, 0));
        send_point(mk_point(OP_FORCE, 10, Q_ONE, Q_ONE, -Q_ONE / 4, 0, 0, Q_ONE,
                            0, 0, 0, 0));
        send_point(mk_point(OP_FORCE, 11, 0, 0, -3 * Q_ONE, 0, 0, 0, 0, 0, 0, 0));
        send_point(mk_point(OP_DIFF, 5, 0, 0, Q_ONE, 0, 0, 0, 0, 0, 0, -Q_ONE / 2));
        send_point(mk_point(OP_DIFF, 4, 0, 0, Q_ONE, 0, 0, 0, 0, 0, 0, Q_ONE));
        wait_results_done();

        s.nx = Q_MAX;
        s.ny = Q_MIN;
        s.nz = Q_MAX;
        s.plane_off = Q_MAX;
        s.stiff = 32'h7FFF_FFFF;
        s.damp = 32'h7FFF_FFFF;
        s.idx_first = -5;
        s.idx_last = 1023;
        load_setup(s);
        send_point(mk_point(OP_FORCE, 600, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                            0, 0, 0, 0));
        send_point(mk_point(OP_DIFF, 600, Q_MAX, Q_MIN, Q_MAX, 0, 0, 0, 0, 0, 0, Q_MIN));
        send_point(mk_point(OP_REFRESH, 7, -1, -1, -1, 0, 0, 0, 0, 0, 0, 0));
        send_point(mk_point(OP_DIFF, 7, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0, 0, 0, Q_ONE));
        wait_results_done();
    endtask

    task automatic test_random_stream(int n_items, int idle_send, int idle_recv);
        int start, next_setup;
        send_idle_pct = idle_send;
        recv_idle_pct = idle_recv;
        start = items_sent;
        next_setup = 0;
        while (items_sent - start < n_items) begin
            if (items_sent - start >= next_setup) begin
                wait_results_done();
                load_setup(random_plane());
                next_setup += $urandom_range(60, 160);
            end
            contact_pass();
        end
        wait_results_done();
    endtask

    // The receiver stops for a long stretch while points keep coming, so the
    // pipeline fills and the input stalls.
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_results_done();
        stall_len <= 400;
        for (int n = 0; n < 48; n++) begin
            send_point(pass_point(n % 2 == 1 ? OP_DIFF : OP_FORCE, 10'(n / 2)));
        end
        wait_results_done();
    endtask

    always @(posedge i_clk) begin
        if (stall_len > 0) begin
            i_out_ready <= 1'b0;
            stall_len <= stall_len - 1;
        end else begin
            i_out_ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    task automatic check_field(string name, logic signed [Q_W-1:0] want,
                               logic signed [Q_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_sums.size() == 0) begin
                $error("result transaction with no point pending");
                mismatches++;
            end else begin
                oldest = expected_sums.pop_front();
                check_field("sum_x", oldest.sum_x, o_sum_x);
                check_field("sum_y", oldest.sum_y, o_sum_y);
                check_field("sum_z", oldest.sum_z, o_sum_z);
                check_field("in_contact", Q_W'(oldest.contact), Q_W'(o_in_contact));
                check_field("depth", oldest.depth, o_depth);
            end
        end
    end

    initial begin
        #3200000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_random_stream(520, 35, 80);
        test_output_stall();
        test_random_stream(520, 80, 35);
        test_random_stream(520, 0, 0);
        wait_results_done();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_sums.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
src/ppcf_pkg.sv
src/ppcf_contact_mem.sv
src/plane_penalty_contact_force.sv
tb/tb_plane_penalty_contact_force.sv
